FILE: design/ggm_pkg.sv
// shared types, constants and the envelope table for the granular grain mixer
package ggm_pkg;

	localparam int SOURCE_DEPTH     = 65536;
	localparam int MAX_GRAINS       = 64;
	localparam int ENVELOPE_ENTRIES = 1024;

	localparam int SRC_AW   = $clog2(SOURCE_DEPTH);
	localparam int GRAIN_AW = $clog2(MAX_GRAINS);
	localparam int ENV_AW   = $clog2(ENVELOPE_ENTRIES);
	localparam int CNT_W    = 7;

	localparam logic [24:0] PHASE_ONE = 25'h100_0000;

	// operation codes
	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_START  = 2'd1,
		OP_RENDER = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	// register indexes
	localparam logic [1:0] REG_MASTER_GAIN   = 2'd0;
	localparam logic [1:0] REG_SOURCE_LENGTH = 2'd1;

	// one grain slot as stored in the grain memory
	typedef struct packed {
		logic [15:0]        start;
		logic [16:0]        len;
		logic [15:0]        pitch;
		logic signed [15:0] pan;
		logic               rev;
		logic [24:0]        phase;
		logic [24:0]        step;
	} grain_rec_t;

	typedef logic [15:0] env_tab_t [ENVELOPE_ENTRIES];

	// hann window, sin^2 from a 13th order taylor series in q30
	function automatic env_tab_t build_env();
		env_tab_t           tab;
		longint unsigned    m, t, t2, term, s, sq, q;
		longint             sum;
		int                 i;
		for (i = 0; i < ENVELOPE_ENTRIES; i++) begin
			m = (i < ENVELOPE_ENTRIES - i) ? longint'(i) : longint'(ENVELOPE_ENTRIES - i);
			t = (64'd3373259426 * m) >> ENV_AW;
			t2 = (t * t) >> 30;
			term = t;
			sum = longint'(t);
			// taylor terms 3 through 13, alternating sign
			term = ((term * t2) >> 30) / 64'd6;
			sum = sum - longint'(term);
			term = ((term * t2) >> 30) / 64'd20;
			sum = sum + longint'(term);
			term = ((term * t2) >> 30) / 64'd42;
			sum = sum - longint'(term);
			term = ((term * t2) >> 30) / 64'd72;
			sum = sum + longint'(term);
			term = ((term * t2) >> 30) / 64'd110;
			sum = sum - longint'(term);
			term = ((term * t2) >> 30) / 64'd156;
			sum = sum + longint'(term);
			if (sum < 0)
				sum = 0;
			s = longint'(sum);
			if (s > 64'd1073741824)
				s = 64'd1073741824;
			sq = (s * s) >> 30;
			q = (sq + 64'd16384) >> 15;
			if (q > 64'd32768)
				q = 64'd32768;
			tab[i] = q[15:0];
		end
		return tab;
	endfunction

	localparam env_tab_t ENV_TABLE = build_env();

endpackage

FILE: design/ggm_ram.sv
// generic single port write, registered read memory
module ggm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

FILE: design/granular_grain_mixer.sv
// granular grain mixer: source memory, grain table and sequential stereo renderer
//
// One input channel (in_valid / in_stall) carries an op and its fields; each
// accepted transaction yields exactly one result transaction on the output
// channel (out_valid / out_stall). Ops: load one source sample, start a grain
// (status 1 when all 64 slots are busy), render one stereo frame, clear all.
// Configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) set the
// master gain and the source length; cfg_ready is always high.
// Sequence: load, clear and a dropped start go straight to the result; a
// start scans the slots for a free one, then runs the divider for the phase
// step; a render visits every slot, retires finished grains and runs each
// live grain through the one shared 33x18 multiplier, then applies the
// master gain.
// in_stall is high while an item is in work; the next item is accepted in the
// cycle after the previous result is issued, while that result may still
// wait in the output register. A held out_stall blocks only the finishing of
// the following item. Reset clears the grain valid bits, the active count,
// out_valid and the registers (gain 4096, source length 65536); the source
// and grain memories hold no reset value.
module granular_grain_mixer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          op,
	input  logic [15:0]         sample_addr,
	input  logic signed [15:0]  sample_value,
	input  logic [15:0]         grain_start,
	input  logic [16:0]         grain_length,
	input  logic [15:0]         pitch_ratio,
	input  logic signed [15:0]  pan,
	input  logic                reversed,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  left_out,
	output logic signed [15:0]  right_out,
	output logic                status,
	output logic [ggm_pkg::CNT_W-1:0] active_count,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [16:0]         cfg_data
);
	import ggm_pkg::*;

	typedef enum logic [22:0] {
		S_IDLE = 23'h000001,
		S_SCAN = 23'h000002,
		S_DIV  = 23'h000004,
		S_RD   = 23'h000008,
		S_LD   = 23'h000010,
		S_M1   = 23'h000020,
		S_M2   = 23'h000040,
		S_M3   = 23'h000080,
		S_M4   = 23'h000100,
		S_RD0  = 23'h000200,
		S_RD1  = 23'h000400,
		S_RD2  = 23'h000800,
		S_I0   = 23'h001000,
		S_I1   = 23'h002000,
		S_I2   = 23'h004000,
		S_E    = 23'h008000,
		S_P0   = 23'h010000,
		S_P1   = 23'h020000,
		S_P2   = 23'h040000,
		S_G0   = 23'h080000,
		S_G1   = 23'h100000,
		S_G2   = 23'h200000,
		S_DONE = 23'h400000
	} state_t;

	localparam logic [GRAIN_AW-1:0] LAST_GRAIN = GRAIN_AW'(MAX_GRAINS - 1);
	localparam logic [4:0] DIV_LAST = 5'd24;

	state_t state_q;

	logic [15:0] gain_q;
	logic [16:0] srclen_q;

	// captured transaction
	logic [1:0]         op_q;
	logic [15:0]        start_q;
	logic [16:0]        len_q;
	logic [15:0]        pitch_q;
	logic signed [15:0] pan_q;
	logic               rev_q;

	logic [MAX_GRAINS-1:0] valid_q;
	logic [CNT_W-1:0]      count_q;
	logic [GRAIN_AW-1:0]   g_q;

	// divider
	logic [24:0] num_q;
	logic [17:0] rem_q;
	logic [4:0]  div_cnt_q;
	logic [17:0] rem_sh;
	logic        q_bit;
	logic [17:0] rem_nx;

	// render datapath
	grain_rec_t         rec_q;
	grain_rec_t         grain_rdata;
	grain_rec_t         grain_wdata;
	logic               grain_we;
	logic [15:0]        env_q;
	logic [40:0]        p1_q;
	logic [39:0]        lo_q;
	logic [57:0]        prod;
	logic [21:0]        pos_q;
	logic [21:0]        pos1;
	logic [14:0]        frac_q;
	logic               ok0_q, ok1_q;
	logic signed [15:0] s0_q, s1_q;
	logic signed [50:0] t_q;
	logic signed [50:0] isum;
	logic signed [16:0] s_q;
	logic signed [32:0] se_q;
	logic signed [23:0] acc_l_q, acc_r_q;
	logic [24:0]        rp;
	logic [24:0]        new_phase;
	logic [15:0]        src_rdata;
	logic               src_re;
	logic [SRC_AW-1:0]  src_raddr;

	// shared multiplier
	logic signed [32:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [50:0] mul_q;
	logic signed [50:0] gshift;

	// result
	logic signed [15:0] res_l_q, res_r_q;
	logic               res_st_q;

	logic in_acc;
	logic out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid || !out_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= 16'd4096;
			srclen_q <= 17'h10000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MASTER_GAIN:   gain_q <= cfg_data[15:0];
				REG_SOURCE_LENGTH: srclen_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// source memory
	ggm_ram #(.WIDTH(16), .DEPTH(SOURCE_DEPTH)) u_src (
		.clk   (clk),
		.we    (in_acc && (op == OP_LOAD)),
		.waddr (sample_addr[SRC_AW-1:0]),
		.wdata (sample_value),
		.re    (src_re),
		.raddr (src_raddr),
		.rdata (src_rdata)
	);

	assign pos1      = pos_q + 22'd1;
	assign src_re    = (state_q == S_RD0) || (state_q == S_RD1);
	assign src_raddr = (state_q == S_RD0) ? pos_q[SRC_AW-1:0] : pos1[SRC_AW-1:0];

	// grain memory
	ggm_ram #(.WIDTH($bits(grain_rec_t)), .DEPTH(MAX_GRAINS)) u_grain (
		.clk   (clk),
		.we    (grain_we),
		.waddr (g_q),
		.wdata (grain_wdata),
		.re    (state_q == S_RD),
		.raddr (g_q),
		.rdata (grain_rdata)
	);

	// divider step, one quotient bit a cycle
	assign rem_sh = {rem_q[16:0], num_q[24]};
	assign q_bit  = (rem_sh >= {1'b0, len_q});
	assign rem_nx = q_bit ? (rem_sh - {1'b0, len_q}) : rem_sh;

	assign rp        = rec_q.rev ? (PHASE_ONE - rec_q.phase) : rec_q.phase;
	assign new_phase = rec_q.phase + rec_q.step;
	assign prod      = {mul_q[33:0], 24'd0} + {18'd0, lo_q};
	assign isum      = t_q + mul_q;
	assign gshift    = mul_q >>> 12;

	// grain memory write: new slot or phase write back
	always_comb begin
		grain_we    = 1'b0;
		grain_wdata = rec_q;
		if (state_q == S_DIV && div_cnt_q == DIV_LAST) begin
			grain_we          = 1'b1;
			grain_wdata.start = start_q;
			grain_wdata.len   = len_q;
			grain_wdata.pitch = pitch_q;
			grain_wdata.pan   = pan_q;
			grain_wdata.rev   = rev_q;
			grain_wdata.phase = (len_q == 17'd0) ? PHASE_ONE : 25'd0;
			grain_wdata.step  = (len_q == 17'd0) ? 25'd0 : {num_q[23:0], q_bit};
		end else if (state_q == S_P2) begin
			grain_we          = 1'b1;
			grain_wdata.phase = new_phase;
		end
	end

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_M1: begin
				mul_a = $signed({8'd0, rp});
				mul_b = $signed({1'b0, rec_q.len});
			end
			S_M2: begin
				mul_a = $signed({9'd0, mul_q[23:0]});
				mul_b = $signed({2'd0, rec_q.pitch});
			end
			S_M3: begin
				mul_a = $signed({16'd0, p1_q[40:24]});
				mul_b = $signed({2'd0, rec_q.pitch});
			end
			S_I0: begin
				mul_a = 33'(s0_q);
				mul_b = 18'sd32768 - $signed({3'd0, frac_q});
			end
			S_I1: begin
				mul_a = 33'(s1_q);
				mul_b = $signed({3'd0, frac_q});
			end
			S_E: begin
				mul_a = 33'(s_q);
				mul_b = $signed({2'd0, env_q});
			end
			S_P0: begin
				mul_a = mul_q[32:0];
				mul_b = 18'sd32768 - 18'(rec_q.pan);
			end
			S_P1: begin
				mul_a = se_q;
				mul_b = 18'sd32768 + 18'(rec_q.pan);
			end
			S_G0: begin
				mul_a = 33'(acc_l_q);
				mul_b = $signed({2'd0, gain_q});
			end
			S_G1: begin
				mul_a = 33'(acc_r_q);
				mul_b = $signed({2'd0, gain_q});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	// saturate a scaled sum to 16 bits
	function automatic logic signed [15:0] sat16(input logic signed [50:0] v);
		if (v > 51'sd32767)
			return 16'sh7fff;
		else if (v < -51'sd32768)
			return 16'sh8000;
		else
			return v[15:0];
	endfunction

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q     <= op;
				start_q  <= grain_start;
				len_q    <= grain_length;
				pitch_q  <= pitch_ratio;
				pan_q    <= pan;
				rev_q    <= reversed;
				acc_l_q  <= '0;
				acc_r_q  <= '0;
				res_l_q  <= '0;
				res_r_q  <= '0;
				res_st_q <= in_valid && (op == OP_START) && (count_q == CNT_W'(MAX_GRAINS));
				rem_q    <= '0;
				div_cnt_q <= '0;
				num_q    <= PHASE_ONE + {8'd0, grain_length} - 25'd1;
			end
			S_SCAN: begin
				rem_q     <= '0;
				div_cnt_q <= '0;
				num_q     <= PHASE_ONE + {8'd0, len_q} - 25'd1;
			end
			S_DIV: begin
				rem_q     <= rem_nx;
				num_q     <= {num_q[23:0], q_bit};
				div_cnt_q <= div_cnt_q + 5'd1;
			end
			S_LD: begin
				rec_q <= grain_rdata;
				env_q <= ENV_TABLE[grain_rdata.phase[23 -: ENV_AW]];
			end
			S_M2: p1_q <= mul_q[40:0];
			S_M3: lo_q <= mul_q[39:0];
			S_M4: begin
				pos_q  <= {6'd0, rec_q.start} + {1'b0, prod[57:37]};
				frac_q <= prod[36:22];
			end
			S_RD0: ok0_q <= (pos_q < {5'd0, srclen_q}) && (pos_q < 22'(SOURCE_DEPTH));
			S_RD1: begin
				s0_q  <= ok0_q ? $signed(src_rdata) : 16'sd0;
				ok1_q <= (pos1 < {5'd0, srclen_q}) && (pos1 < 22'(SOURCE_DEPTH));
			end
			S_RD2: s1_q <= ok1_q ? $signed(src_rdata) : 16'sd0;
			S_I1:  t_q <= mul_q;
			S_I2:  s_q <= 17'(isum >>> 15);
			S_P0:  se_q <= mul_q[32:0];
			S_P1:  acc_l_q <= acc_l_q + 24'(mul_q >>> 31);
			S_P2:  acc_r_q <= acc_r_q + 24'(mul_q >>> 31);
			S_G1:  res_l_q <= sat16(gshift);
			S_G2:  res_r_q <= sat16(gshift);
			default: ;
		endcase
	end

	// sequencer and grain bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			count_q <= '0;
			g_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					g_q <= '0;
					if (in_valid) begin
						case (op)
							OP_START:
								state_q <= (count_q == CNT_W'(MAX_GRAINS)) ? S_DONE : S_SCAN;
							OP_RENDER: state_q <= S_RD;
							OP_CLEAR: begin
								valid_q <= '0;
								count_q <= '0;
								state_q <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_SCAN: begin
					if (!valid_q[g_q])
						state_q <= S_DIV;
					else
						g_q <= g_q + GRAIN_AW'(1);
				end
				S_DIV: begin
					if (div_cnt_q == DIV_LAST) begin
						valid_q[g_q] <= 1'b1;
						count_q <= count_q + CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_RD: begin
					if (valid_q[g_q])
						state_q <= S_LD;
					else if (g_q == LAST_GRAIN)
						state_q <= S_G0;
					else
						g_q <= g_q + GRAIN_AW'(1);
				end
				S_LD: begin
					if (grain_rdata.phase >= PHASE_ONE) begin
						valid_q[g_q] <= 1'b0;
						count_q <= count_q - CNT_W'(1);
						if (g_q == LAST_GRAIN) begin
							state_q <= S_G0;
						end else begin
							g_q <= g_q + GRAIN_AW'(1);
							state_q <= S_RD;
						end
					end else begin
						state_q <= S_M1;
					end
				end
				S_M1:  state_q <= S_M2;
				S_M2:  state_q <= S_M3;
				S_M3:  state_q <= S_M4;
				S_M4:  state_q <= S_RD0;
				S_RD0: state_q <= S_RD1;
				S_RD1: state_q <= S_RD2;
				S_RD2: state_q <= S_I0;
				S_I0:  state_q <= S_I1;
				S_I1:  state_q <= S_I2;
				S_I2:  state_q <= S_E;
				S_E:   state_q <= S_P0;
				S_P0:  state_q <= S_P1;
				S_P1:  state_q <= S_P2;
				S_P2: begin
					if (new_phase >= PHASE_ONE) begin
						valid_q[g_q] <= 1'b0;
						count_q <= count_q - CNT_W'(1);
					end
					if (g_q == LAST_GRAIN) begin
						state_q <= S_G0;
					end else begin
						g_q <= g_q + GRAIN_AW'(1);
						state_q <= S_RD;
					end
				end
				S_G0: state_q <= S_G1;
				S_G1: state_q <= S_G2;
				S_G2: state_q <= S_DONE;
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			left_out     <= (op_q == OP_RENDER) ? res_l_q : 16'sd0;
			right_out    <= (op_q == OP_RENDER) ? res_r_q : 16'sd0;
			status       <= res_st_q;
			active_count <= count_q;
		end
	end

endmodule

FILE: bench/ggm_checker.sv
// transaction monitor, grain mixer predictor and result comparison
`timescale 1ns / 100ps

module ggm_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [1:0]          op,
	input  logic [15:0]         sample_addr,
	input  logic signed [15:0]  sample_value,
	input  logic [15:0]         grain_start,
	input  logic [16:0]         grain_length,
	input  logic [15:0]         pitch_ratio,
	input  logic signed [15:0]  pan,
	input  logic                reversed,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic signed [15:0]  left_out,
	input  logic signed [15:0]  right_out,
	input  logic                status,
	input  logic [6:0]          active_count,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [16:0]         cfg_data,
	output int                  errors,
	output int                  pending
);
	import ggm_pkg::*;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic               drop;
		logic [6:0]         count;
	} mix_result_t;

	localparam int NSLOT = 64;
	localparam int NENV  = 1024;

	mix_result_t        expected_mix[$];
	logic [15:0]        gain;
	logic [16:0]        src_len;
	logic [15:0]        src_mem [65536];
	logic [15:0]        hann [NENV];
	logic               slot_on [NSLOT];
	logic [15:0]        slot_start [NSLOT];
	logic [16:0]        slot_len [NSLOT];
	logic [15:0]        slot_pitch [NSLOT];
	logic signed [15:0] slot_pan [NSLOT];
	logic               slot_rev [NSLOT];
	logic [31:0]        slot_phase [NSLOT];
	logic [31:0]        slot_step [NSLOT];

	// sin^2 window entry via integer taylor series in q30
	function automatic logic [15:0] hann_weight(int idx);
		longint unsigned m, x, x2, term, s, sq, q;
		longint acc;
		m = (idx < NENV - idx) ? idx : NENV - idx;
		x = (64'd3373259426 * m) / NENV;
		x2 = (x * x) >> 30;
		term = x;
		acc = x;
		for (int k = 1; k <= 6; k++) begin
			term = ((term * x2) >> 30) / longint'(2 * k * (2 * k + 1));
			acc = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
		end
		if (acc < 0) acc = 0;
		s = acc;
		if (s > 64'd1073741824) s = 64'd1073741824;
		sq = (s * s) >> 30;
		q = (sq + 64'd16384) >> 15;
		if (q > 64'd32768) q = 64'd32768;
		return q[15:0];
	endfunction

	function automatic longint src_read(logic [31:0] a);
		if (a < src_len && a < 65536)
			return longint'(signed'(src_mem[a[15:0]]));
		return 0;
	endfunction

	function automatic longint sat16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// advance the grain table by one transaction and queue its result
	task automatic mix_step();
		mix_result_t r;
		int          g;
		logic [31:0] rp, pos;
		longint unsigned prod;
		longint      s, se, pn, frac, acc_l, acc_r;
		r = '0;
		acc_l = 0;
		acc_r = 0;
		case (op_t'(op))
			OP_LOAD: src_mem[sample_addr] = sample_value;
			OP_START: begin
				g = 0;
				while (g < NSLOT && slot_on[g]) g++;
				if (g == NSLOT) r.drop = 1'b1;
				else begin
					slot_on[g] = 1'b1;
					slot_start[g] = grain_start;
					slot_len[g] = grain_length;
					slot_pitch[g] = pitch_ratio;
					slot_pan[g] = pan;
					slot_rev[g] = reversed;
					slot_phase[g] = (grain_length == 0) ? 32'h100_0000 : 32'd0;
					slot_step[g] = (grain_length == 0) ? 32'd0 :
						(32'h100_0000 + grain_length - 1) / grain_length;
				end
			end
			OP_RENDER: begin
				for (g = 0; g < NSLOT; g++) begin
					if (!slot_on[g]) continue;
					if (slot_phase[g] >= 32'h100_0000) begin
						slot_on[g] = 1'b0;
						continue;
					end
					rp = slot_rev[g] ? 32'h100_0000 - slot_phase[g] : slot_phase[g];
					prod = rp;
					prod = prod * slot_len[g];
					prod = prod * slot_pitch[g];
					pos = slot_start[g] + 32'(prod >> 37);
					frac = longint'(prod[36:22]);
					s = (src_read(pos) * (32768 - frac) + src_read(pos + 1) * frac) >>> 15;
					se = s * longint'(hann[slot_phase[g][23:14]]);
					pn = slot_pan[g];
					acc_l += (se * (32768 - pn)) >>> 31;
					acc_r += (se * (32768 + pn)) >>> 31;
					slot_phase[g] = slot_phase[g] + slot_step[g];
					if (slot_phase[g] >= 32'h100_0000) slot_on[g] = 1'b0;
				end
				r.left = 16'(sat16((acc_l * longint'(gain)) >>> 12));
				r.right = 16'(sat16((acc_r * longint'(gain)) >>> 12));
			end
			default: for (g = 0; g < NSLOT; g++) slot_on[g] = 1'b0;
		endcase
		for (g = 0; g < NSLOT; g++) r.count += slot_on[g];
		expected_mix.push_back(r);
	endtask

	initial begin
		for (int i = 0; i < NENV; i++) hann[i] = hann_weight(i);
		for (int i = 0; i < 65536; i++) src_mem[i] = '0;
		for (int i = 0; i < NSLOT; i++) slot_on[i] = 1'b0;
		gain = 16'd4096;
		src_len = 17'd65536;
		errors = 0;
		pending = 0;
	end

	// compare result transactions, then track config and input transactions
	always @(posedge clk) begin
		mix_result_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_mix.size() == 0) begin
					$error("result with none expected");
					errors++;
				end else begin
					e = expected_mix.pop_front();
					if (left_out !== e.left) begin
						$error("left_out expected %0d got %0d", e.left, left_out);
						errors++;
					end
					if (right_out !== e.right) begin
						$error("right_out expected %0d got %0d", e.right, right_out);
						errors++;
					end
					if (status !== e.drop) begin
						$error("status expected %0d got %0d", e.drop, status);
						errors++;
					end
					if (active_count !== e.count) begin
						$error("active_count expected %0d got %0d", e.count, active_count);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_MASTER_GAIN) gain = cfg_data[15:0];
				else if (cfg_index == REG_SOURCE_LENGTH) src_len = cfg_data;
			end
			if (in_valid && !in_stall) mix_step();
			pending = expected_mix.size();
		end
	end

endmodule

FILE: bench/tb_granular_grain_mixer.sv
// stimulus, clock, reset and verdict for the granular grain mixer
`timescale 1ns / 100ps

module tb_granular_grain_mixer;
	import ggm_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         op = OP_LOAD;
	logic [15:0]        sample_addr = '0;
	logic signed [15:0] sample_value = '0;
	logic [15:0]        grain_start = '0;
	logic [16:0]        grain_length = '0;
	logic [15:0]        pitch_ratio = '0;
	logic signed [15:0] pan = '0;
	logic               reversed = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] left_out, right_out;
	logic               status;
	logic [CNT_W-1:0]   active_count;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = REG_MASTER_GAIN;
	logic [16:0]        cfg_data = '0;
	int                 errors, pending;
	int                 quiet_cycles = 0;
	bit                 calm = 1'b0;
	int                 live_len = 1;

	always #5 clk = ~clk;

	granular_grain_mixer dut (.*);

	ggm_checker chk (.*);

	// output side back-pressure
	always @(negedge clk)
		out_stall <= !calm && ($urandom_range(99) < 19);

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// one input transaction, held until taken; valid stays up for a follower
	task automatic send(op_t o, logic [15:0] a, logic [15:0] v, logic [15:0] st,
			logic [16:0] ln, logic [15:0] pr, logic [15:0] pn, logic rv);
		bit taken;
		if (!calm && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			do
				@(negedge clk);
			while (!calm && $urandom_range(99) < 19);
		end
		in_valid <= 1'b1;
		op <= o;
		sample_addr <= a;
		sample_value <= v;
		grain_start <= st;
		grain_length <= ln;
		pitch_ratio <= pr;
		pan <= pn;
		reversed <= rv;
		do begin
			#1 taken = !in_stall;
			@(posedge clk);
			@(negedge clk);
		end while (!taken);
	endtask

	// drop the input valid when no transaction follows
	task automatic idle_input();
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	// register write once every result is back
	task automatic write_reg(logic [1:0] idx, logic [16:0] val);
		bit taken;
		idle_input();
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			#1 taken = cfg_ready;
			@(posedge clk);
			@(negedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
		if (idx == REG_SOURCE_LENGTH) live_len = int'(val);
	endtask

	task automatic start_grain(logic [15:0] st, logic [16:0] ln, logic [15:0] pr,
			logic [15:0] pn, logic rv);
		send(OP_START, 16'($urandom), 16'($urandom), st, ln, pr, pn, rv);
	endtask

	// random mix of operations, grains mostly short and inside the source
	task automatic random_items(int n);
		int r;
		logic [16:0] ln;
		logic [15:0] st;
		logic [15:0] ad;
		for (int i = 0; i < n; i++) begin
			calm = (i >= n / 3 && i < n / 2);
			r = $urandom_range(99);
			if (r < 12) begin
				ad = ($urandom_range(99) < 80) ? 16'($urandom_range(live_len - 1))
					: 16'($urandom);
				send(OP_LOAD, ad, 16'($urandom), 16'($urandom), 17'($urandom),
					16'($urandom), 16'($urandom), 1'($urandom));
			end else if (r < 45) begin
				r = $urandom_range(99);
				ln = (r < 70) ? 17'($urandom_range(40, 1)) : (r < 95) ?
					17'($urandom_range(2000, 41)) : 17'($urandom_range(65536, 0));
				st = ($urandom_range(99) < 85) ? 16'($urandom_range(live_len - 1))
					: 16'($urandom);
				start_grain(st, ln, 16'($urandom), 16'($urandom), 1'($urandom));
			end else if (r < 93)
				send(OP_RENDER, 16'($urandom), 16'($urandom), 16'($urandom), 17'($urandom),
					16'($urandom), 16'($urandom), 1'($urandom));
			else
				send(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 17'($urandom),
					16'($urandom), 16'($urandom), 1'($urandom));
		end
		calm = 1'b0;
	endtask

	task automatic render();
		send(OP_RENDER, '0, '0, '0, '0, '0, '0, 1'b0);
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: tiny source, edge grains, unknown register indexes
		write_reg(REG_SOURCE_LENGTH, 17'd1);
		write_reg(2'd2, 17'h1ffff);
		write_reg(2'd3, 17'd0);
		send(OP_LOAD, 16'd65535, 16'h8000, '0, '0, '0, '0, 1'b0);
		send(OP_LOAD, 16'd0, 16'h7fff, '0, '0, '0, '0, 1'b0);
		start_grain(16'd0, 17'd0, 16'd8192, 16'd0, 1'b0);
		start_grain(16'd0, 17'd1, 16'hffff, 16'h7fff, 1'b1);
		start_grain(16'hffff, 17'd65536, 16'd8192, 16'h8000, 1'b0);
		start_grain(16'd0, 17'd3, 16'd0, 16'd0, 1'b0);
		start_grain(16'd0, 17'd8, 16'd1024, 16'h8000, 1'b1);
		repeat (3) render();
		send(OP_CLEAR, '0, '0, '0, '0, '0, '0, 1'b0);
		// fill every slot, one more start is dropped
		for (int i = 0; i < 65; i++)
			start_grain(16'd0, 17'd4, 16'd4096, 16'($urandom), 1'b0);
		render();
		send(OP_CLEAR, '0, '0, '0, '0, '0, '0, 1'b0);

		// full gain, short source
		write_reg(REG_MASTER_GAIN, 17'd65535);
		for (int a = 0; a < 64; a++)
			send(OP_LOAD, 16'(a), 16'($urandom), '0, '0, '0, '0, 1'b0);
		write_reg(REG_SOURCE_LENGTH, 17'd64);
		random_items(120);

		// muted output, shorter source
		write_reg(REG_MASTER_GAIN, 17'd0);
		write_reg(REG_SOURCE_LENGTH, 17'($urandom_range(64, 1)));
		random_items(60);

		// longer source, nominal and random gain
		for (int a = 64; a < 128; a++)
			send(OP_LOAD, 16'(a), 16'($urandom), '0, '0, '0, '0, 1'b0);
		write_reg(REG_SOURCE_LENGTH, 17'd128);
		write_reg(REG_MASTER_GAIN, 17'd4096);
		random_items(60);
		write_reg(REG_MASTER_GAIN, 17'($urandom_range(65535)));
		random_items(50);

		idle_input();
		while (pending != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
